[hdl/tcw_pkg.sv]
`timescale 1ns / 1ps

package tcw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   // field widths
   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int ATTR_W   = 8;
   localparam int CELL_W   = CHAR_W + ATTR_W;
   localparam int INDEX_W  = 11;
   localparam int CURSOR_W = 11;

   // derived widths
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int CNT_W  = $clog2(CELL_COUNT + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   // words in flight: queue slots, the one in the back, the output register
   localparam int PEND_MAX = QUEUE_DEPTH + 2;
   localparam int PEND_W   = $clog2(PEND_MAX + 1);

   // tab expands to this many spaces
   localparam int TAB_LEN = 4;
   localparam int TAB_W   = $clog2(TAB_LEN + 1);

   // cursor limits
   localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
   localparam logic [ADDR_W-1:0] BOTTOM_POS = ADDR_W'((ROWS - 1) * COLUMNS);

   // commands
   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // control characters
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

   localparam logic [ATTR_W-1:0] RESET_COLOUR = 8'h04;

   // classified operations
   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_RETURN,
      OP_TAB,
      OP_BACKSPACE,
      OP_READ,
      OP_CLEAR,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [CHAR_W-1:0]    char_code;
      logic [INDEX_W-1:0]   cell_index;
   } item_type;

endpackage

[hdl/tcw_ram.sv]
`timescale 1ns / 1ps

module tcw_ram #(
   parameter int Width = 16,
   parameter int Depth = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/tcw_front.sv]
`timescale 1ns / 1ps

module tcw_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tcw_pkg::CMD_W-1:0]     req_cmd,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::INDEX_W-1:0]   req_cell_index,
   output logic                          q_valid,
   output tcw_pkg::item_type             q_item,
   input  logic                          q_pop
);

   import tcw_pkg::*;

   item_type             slot_ff [QUEUE_DEPTH];
   item_type             slot_in;
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push;

   // classify the incoming word
   always_comb begin
      slot_in.char_code  = req_char_code;
      slot_in.cell_index = req_cell_index;
      case (req_cmd)
         CMD_PUT: begin
            case (req_char_code)
               CH_NEWLINE:   slot_in.op = OP_NEWLINE;
               CH_RETURN:    slot_in.op = OP_RETURN;
               CH_TAB:       slot_in.op = OP_TAB;
               CH_BACKSPACE: slot_in.op = OP_BACKSPACE;
               default:      slot_in.op = OP_PUT;
            endcase
         end
         CMD_READ:  slot_in.op = OP_READ;
         CMD_CLEAR: slot_in.op = OP_CLEAR;
         default:   slot_in.op = OP_NOP;
      endcase
   end

   assign req_stall = (count_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

[hdl/tcw_back.sv]
`timescale 1ns / 1ps

module tcw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  tcw_pkg::item_type             q_item,
   output logic                          q_pop,
   input  logic                          csr_write_enable,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_write_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_cell_data,
   output logic [tcw_pkg::CURSOR_W-1:0]  rsp_cursor_pos
);

   import tcw_pkg::*;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_TAB,
      ST_SCROLL,
      ST_READ,
      ST_WAIT
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 init_ff, init_in;
   logic [ATTR_W-1:0]    fill_attr_ff, fill_attr_in;
   logic [ATTR_W-1:0]    colour_ff, colour_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ADDR_W-1:0]    pos_ff, pos_in;
   logic [TAB_W-1:0]     tab_left_ff, tab_left_in;
   logic                 in_range_ff, in_range_in;
   logic [CELL_W-1:0]    res_data_ff, res_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]    rsp_data_ff, rsp_data_in;
   logic [CURSOR_W-1:0]  rsp_pos_ff, rsp_pos_in;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [CELL_W-1:0]    ram_wdata;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [CELL_W-1:0]    ram_rdata;

   logic                 out_free;
   logic                 load_rsp;
   logic [CELL_W-1:0]    load_data;
   logic [CELL_W-1:0]    blank_cell;
   logic [CNT_W-1:0]     src_cnt;

   // cursor after a plain character
   logic                 col_end;
   logic                 adv_scroll;
   logic [ROW_W-1:0]     adv_row;
   logic [COL_W-1:0]     adv_col;
   logic [ADDR_W-1:0]    adv_pos;

   // cursor after a newline
   logic                 nl_scroll;
   logic [ROW_W-1:0]     nl_row;
   logic [ADDR_W-1:0]    nl_pos;

   tcw_ram #(
      .Width (CELL_W),
      .Depth (CELL_COUNT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign blank_cell = {colour_ff, BLANK_CHAR};
   assign src_cnt    = cnt_ff + CNT_W'(COLUMNS);

   // plain character advance, scroll when leaving the bottom row
   assign col_end    = (col_ff == COL_LAST);
   assign adv_scroll = col_end && (row_ff == ROW_LAST);
   assign adv_col    = col_end ? '0 : col_ff + 1'b1;
   assign adv_row    = (col_end && !adv_scroll) ? row_ff + 1'b1 : row_ff;
   assign adv_pos    = adv_scroll ? BOTTOM_POS : pos_ff + 1'b1;

   // newline advance
   assign nl_scroll = (row_ff == ROW_LAST);
   assign nl_row    = nl_scroll ? row_ff : row_ff + 1'b1;
   assign nl_pos    = nl_scroll ? BOTTOM_POS
                                : pos_ff - ADDR_W'(col_ff) + ADDR_W'(COLUMNS);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      init_in      = init_ff;
      fill_attr_in = fill_attr_ff;
      colour_in    = colour_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pos_in       = pos_ff;
      tab_left_in  = tab_left_ff;
      in_range_in  = in_range_ff;
      res_data_in  = res_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = {colour_ff, q_item.char_code};
      ram_raddr    = ADDR_W'(q_item.cell_index);
      q_pop        = 1'b0;
      load_rsp     = 1'b0;
      load_data    = '0;

      case (state_ff)
         // blank every cell, after reset or for a clear
         ST_FILL: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[ADDR_W-1:0];
            ram_wdata = {fill_attr_ff, BLANK_CHAR};
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               cnt_in = '0;
               if (init_ff) begin
                  init_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_WAIT;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // take a word; short ones finish here
         ST_IDLE: begin
            if (q_valid && out_free) begin
               q_pop       = 1'b1;
               res_data_in = '0;
               tab_left_in = '0;
               cnt_in      = '0;
               case (q_item.op)
                  OP_PUT: begin
                     ram_we = 1'b1;
                     row_in = adv_row;
                     col_in = adv_col;
                     pos_in = adv_pos;
                     if (adv_scroll) begin
                        state_in = ST_SCROLL;
                     end else begin
                        load_rsp = 1'b1;
                     end
                  end
                  OP_NEWLINE: begin
                     row_in = nl_row;
                     col_in = '0;
                     pos_in = nl_pos;
                     if (nl_scroll) begin
                        state_in = ST_SCROLL;
                     end else begin
                        load_rsp = 1'b1;
                     end
                  end
                  OP_RETURN: begin
                     col_in   = '0;
                     pos_in   = pos_ff - ADDR_W'(col_ff);
                     load_rsp = 1'b1;
                  end
                  OP_TAB: begin
                     tab_left_in = TAB_W'(TAB_LEN);
                     state_in    = ST_TAB;
                  end
                  OP_BACKSPACE: begin
                     ram_we    = 1'b1;
                     ram_wdata = blank_cell;
                     load_rsp  = 1'b1;
                     if (col_ff == '0) begin
                        col_in = COL_LAST;
                        if (row_ff != '0) begin
                           row_in = row_ff - 1'b1;
                           pos_in = pos_ff - 1'b1;
                        end else begin
                           pos_in = ADDR_W'(COLUMNS - 1);
                        end
                     end else begin
                        col_in = col_ff - 1'b1;
                        pos_in = pos_ff - 1'b1;
                     end
                  end
                  OP_READ: begin
                     in_range_in = (32'(q_item.cell_index) < CELL_COUNT);
                     state_in    = ST_READ;
                  end
                  OP_CLEAR: begin
                     fill_attr_in = colour_ff;
                     state_in     = ST_FILL;
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end

         // one space per cycle
         ST_TAB: begin
            ram_we      = 1'b1;
            ram_wdata   = blank_cell;
            row_in      = adv_row;
            col_in      = adv_col;
            pos_in      = adv_pos;
            tab_left_in = tab_left_ff - 1'b1;
            if (adv_scroll) begin
               cnt_in   = '0;
               state_in = ST_SCROLL;
            end else if (tab_left_ff == TAB_W'(1)) begin
               state_in = ST_WAIT;
            end
         end

         // copy each cell one row up, then blank the bottom row
         ST_SCROLL: begin
            ram_raddr = src_cnt[ADDR_W-1:0];
            if (cnt_ff != '0) begin
               ram_we    = 1'b1;
               ram_waddr = ADDR_W'(cnt_ff - 1'b1);
               ram_wdata = (cnt_ff <= CNT_W'(CELL_COUNT - COLUMNS)) ? ram_rdata
                                                                     : blank_cell;
            end
            if (cnt_ff == CNT_W'(CELL_COUNT)) begin
               cnt_in   = '0;
               state_in = (tab_left_ff != '0) ? ST_TAB : ST_WAIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // cell data arrives in the cycle after the address
         ST_READ: begin
            res_data_in = in_range_ff ? ram_rdata : '0;
            state_in    = ST_WAIT;
         end

         // hand the finished word to the output register
         ST_WAIT: begin
            if (out_free) begin
               load_rsp  = 1'b1;
               load_data = res_data_ff;
               state_in  = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // colour register
      if (csr_write_enable) begin
         colour_in = csr_write_data;
      end

      // output register
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = load_data;
         rsp_pos_in   = CURSOR_W'(pos_in);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      in_range_ff <= in_range_in;
      res_data_ff <= res_data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_pos_ff  <= rsp_pos_in;
      if (reset) begin
         state_ff     <= ST_FILL;
         cnt_ff       <= '0;
         init_ff      <= 1'b1;
         fill_attr_ff <= RESET_COLOUR;
         colour_ff    <= RESET_COLOUR;
         row_ff       <= '0;
         col_ff       <= '0;
         pos_ff       <= '0;
         tab_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         init_ff      <= init_in;
         fill_attr_ff <= fill_attr_in;
         colour_ff    <= colour_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         pos_ff       <= pos_in;
         tab_left_ff  <= tab_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_data  = rsp_data_ff;
   assign rsp_cursor_pos = rsp_pos_ff;

endmodule

[hdl/text_console_writer.sv]
`timescale 1ns / 1ps

// channel   direction  handshake               payload
// req_      in         req_valid / req_stall   cmd, char_code, cell_index
// rsp_      out        rsp_valid / rsp_stall   cell_data, cursor_pos
// csr_      in         csr_write_enable        csr_write_data (text colour)
//
// A plain put, return, newline, backspace or unused command finishes in the idle state
// of the back end, a read passes through the read and wait states, a tab through the tab
// and wait states; the front end queues two words meanwhile. Leaving the bottom row
// scrolls the store: one cell copied per cycle over the single store write port.
// A clear blanks every cell. After reset a clearing pass blanks the store; words are
// queued but not executed until it ends. Colour writes are taken at any time.
// A stalled result holds in the output register; the back end takes the next word
// only when that register is free.

module text_console_writer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tcw_pkg::CMD_W-1:0]     req_cmd,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::INDEX_W-1:0]   req_cell_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tcw_pkg::CELL_W-1:0]    rsp_cell_data,
   output logic [tcw_pkg::CURSOR_W-1:0]  rsp_cursor_pos,
   input  logic                          csr_write_enable,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_write_data
);

   import tcw_pkg::*;

   logic      q_valid;
   item_type  q_item;
   logic      q_pop;

   // accept and classify
   tcw_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // execute against the text store
   tcw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_data    (rsp_cell_data),
      .rsp_cursor_pos   (rsp_cursor_pos)
   );

endmodule

[hdl/tcw_checker.sv]
`timescale 1ns / 1ps

module tcw_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [tcw_pkg::CELL_W-1:0]    rsp_cell_data,
   input  logic [tcw_pkg::CURSOR_W-1:0]  rsp_cursor_pos
);

   import tcw_pkg::*;

   logic [PEND_W-1:0] pend_ff, pend_in;
   logic              req_take;
   logic              rsp_take;

   // words accepted but not yet answered
   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      pend_in = pend_ff;
      if (req_take && !rsp_take) begin
         pend_in = pend_ff + 1'b1;
      end else if (!req_take && rsp_take) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // no result comes out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word right after reset");

   // every result answers an accepted word
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != '0)
      else $error("result word with no request outstanding");

   // front queue, back end and output register bound what is in flight
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= PEND_W'(PEND_MAX))
      else $error("more words in flight than the design can hold");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_cell_data) && $stable(rsp_cursor_pos))
      else $error("stalled result word changed");

   // cursor stays on the screen
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CELL_COUNT > 2048) || (rsp_cursor_pos < CURSOR_W'(CELL_COUNT)))
      else $error("cursor position beyond the last cell");

endmodule

bind text_console_writer tcw_checker u_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
   import tcw_pkg::*;

   // the fourth command code does nothing but answer
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      logic [CELL_W-1:0]   cell_data;
      logic [CURSOR_W-1:0] cursor_pos;
   } result_word;

   typedef struct {
      logic [CMD_W-1:0]    cmd;
      logic [CHAR_W-1:0]   ch;
      logic [INDEX_W-1:0]  idx;
      int                  reps;
      bit                  typed;
      logic [CELL_W-1:0]   data;
      logic [CURSOR_W-1:0] pos;
   } stim_row;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd = CMD_PUT;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic [INDEX_W-1:0]   req_cell_index = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [CELL_W-1:0]    rsp_cell_data;
   logic [CURSOR_W-1:0]  rsp_cursor_pos;
   logic                 csr_write_enable = 1'b0;
   logic [ATTR_W-1:0]    csr_write_data = '0;

   text_console_writer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_char_code    (req_char_code),
      .req_cell_index   (req_cell_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_cell_data    (rsp_cell_data),
      .rsp_cursor_pos   (rsp_cursor_pos),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // shadow copy of the screen, cursor and colour
   logic [CELL_W-1:0]  screen_cells [0:CELL_COUNT-1];
   logic [ROW_W:0]     cur_row;
   logic [COL_W:0]     cur_col;
   logic [ATTR_W-1:0]  colour_now;

   result_word cells_due [$];
   stim_row    directed_rows [$];
   int         mismatch_count = 0;
   bit         idle_on = 1'b1;

   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_count < 40)
         $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   function automatic void write_at_cursor(logic [CELL_W-1:0] cell_word);
      int pos;
      pos = cur_row * COLUMNS + cur_col;
      if (pos < CELL_COUNT)
         screen_cells[pos] = cell_word;
   endfunction

   // new line, scrolling when it leaves the bottom row
   function automatic void advance_row();
      int i;
      cur_col = '0;
      cur_row++;
      if (cur_row >= ROWS) begin
         for (i = 0; i + COLUMNS < CELL_COUNT; i++)
            screen_cells[i] = screen_cells[i + COLUMNS];
         for (; i < CELL_COUNT; i++)
            screen_cells[i] = {colour_now, BLANK_CHAR};
         cur_row = (ROW_W+1)'(ROWS - 1);
      end
   endfunction

   function automatic void put_glyph(logic [CHAR_W-1:0] ch);
      write_at_cursor({colour_now, ch});
      cur_col++;
      if (cur_col >= COLUMNS)
         advance_row();
   endfunction

   // expected answer of one word, updating the shadow state
   function automatic result_word console_answer(logic [CMD_W-1:0] cmd,
                                                 logic [CHAR_W-1:0] ch,
                                                 logic [INDEX_W-1:0] idx);
      result_word r;
      int i;
      r.cell_data = '0;
      case (cmd)
         CMD_PUT: begin
            case (ch)
               CH_NEWLINE: advance_row();
               CH_RETURN: cur_col = '0;
               CH_TAB: begin
                  for (i = 0; i < TAB_LEN; i++)
                     put_glyph(BLANK_CHAR);
               end
               CH_BACKSPACE: begin
                  write_at_cursor({colour_now, BLANK_CHAR});
                  if (cur_col == 0) begin
                     cur_col = (COL_W+1)'(COLUMNS - 1);
                     if (cur_row != 0)
                        cur_row--;
                  end else begin
                     cur_col--;
                  end
               end
               default: put_glyph(ch);
            endcase
         end
         CMD_READ: begin
            if (idx < CELL_COUNT)
               r.cell_data = screen_cells[idx];
         end
         CMD_CLEAR: begin
            for (i = 0; i < CELL_COUNT; i++)
               screen_cells[i] = {colour_now, BLANK_CHAR};
         end
         default: ;
      endcase
      r.cursor_pos = CURSOR_W'(cur_row * COLUMNS + cur_col);
      return r;
   endfunction

   // send one word, now and then with a random gap before it
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                            logic [INDEX_W-1:0] idx, bit typed,
                            logic [CELL_W-1:0] data, logic [CURSOR_W-1:0] pos);
      result_word want;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_char_code <= ch;
      req_cell_index <= idx;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      want = console_answer(cmd, ch, idx);
      if (typed) begin
         want.cell_data = data;
         want.cursor_pos = pos;
      end
      cells_due.push_back(want);
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      while (cells_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_colour(logic [ATTR_W-1:0] v);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      colour_now = v;
   endtask

   function automatic void add_row(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                   logic [INDEX_W-1:0] idx, int reps, bit typed,
                                   logic [CELL_W-1:0] data,
                                   logic [CURSOR_W-1:0] pos);
      stim_row r;
      r.cmd = cmd;
      r.ch = ch;
      r.idx = idx;
      r.reps = reps;
      r.typed = typed;
      r.data = data;
      r.pos = pos;
      directed_rows.push_back(r);
   endfunction

   // mostly text and line control, some reads, rare unused commands and clears
   task automatic run_random(int count);
      int n;
      int pick;
      int here;
      logic [CMD_W-1:0]   cmd;
      logic [CHAR_W-1:0]  ch;
      logic [INDEX_W-1:0] idx;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         cmd = CMD_PUT;
         ch = CHAR_W'($urandom_range(0, 255));
         idx = INDEX_W'($urandom_range(0, 2047));
         if (pick < 62) begin
            cmd = CMD_PUT;
         end else if (pick < 70) begin
            ch = CH_NEWLINE;
         end else if (pick < 74) begin
            ch = CH_TAB;
         end else if (pick < 80) begin
            ch = CH_BACKSPACE;
         end else if (pick < 83) begin
            ch = CH_RETURN;
         end else if (pick < 96) begin
            cmd = CMD_READ;
            here = cur_row * COLUMNS + cur_col;
            case ($urandom_range(0, 7))
               0, 1, 2: idx = (here > 100) ? INDEX_W'(here - $urandom_range(0, 100))
                                           : INDEX_W'($urandom_range(0, 100));
               3: idx = INDEX_W'($urandom_range(CELL_COUNT, 2047));
               default: idx = INDEX_W'($urandom_range(0, CELL_COUNT - 1));
            endcase
         end else if (pick < 98) begin
            cmd = CMD_UNUSED;
         end else begin
            cmd = CMD_CLEAR;
         end
         send_word(cmd, ch, idx, 1'b0, '0, '0);
      end
   endtask

   // receiver stalls in bursts
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            if (stall_left == 0)
               rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            stall_left = $urandom_range(1, 17);
            rsp_stall <= 1'b1;
         end
      end
   end

   // compare each accepted result with the oldest one due
   always @(posedge clock) begin
      result_word want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (cells_due.size() == 0) begin
            report_mismatch("result with nothing due", rsp_cell_data, 0);
         end else begin
            want = cells_due.pop_front();
            if (rsp_cell_data !== want.cell_data)
               report_mismatch("cell_data", rsp_cell_data, want.cell_data);
            if (rsp_cursor_pos !== want.cursor_pos)
               report_mismatch("cursor_pos", rsp_cursor_pos, want.cursor_pos);
         end
      end
   end

   initial begin
      int i;
      stim_row r;
      for (i = 0; i < CELL_COUNT; i++)
         screen_cells[i] = {RESET_COLOUR, BLANK_CHAR};
      cur_row = '0;
      cur_col = '0;
      colour_now = RESET_COLOUR;

      // screen after reset, range ends, line control at the corners
      add_row(CMD_READ, 8'h00, 11'd0, 1, 1, 16'h0420, 11'd0);
      add_row(CMD_READ, 8'hFF, 11'd1999, 1, 1, 16'h0420, 11'd0);
      add_row(CMD_READ, 8'h00, 11'd2047, 1, 1, 16'h0000, 11'd0);
      add_row(CMD_READ, 8'h00, 11'd2000, 1, 1, 16'h0000, 11'd0);
      add_row(CMD_UNUSED, 8'hFF, 11'd5, 1, 1, 16'h0000, 11'd0);
      add_row(CMD_PUT, 8'h41, 11'd0, 1, 1, 16'h0000, 11'd1);
      add_row(CMD_PUT, 8'h00, 11'd2047, 1, 1, 16'h0000, 11'd2);
      add_row(CMD_PUT, 8'hFF, 11'd0, 1, 1, 16'h0000, 11'd3);
      add_row(CMD_READ, 8'h00, 11'd0, 1, 1, 16'h0441, 11'd3);
      add_row(CMD_PUT, CH_BACKSPACE, 11'd0, 1, 1, 16'h0000, 11'd2);
      add_row(CMD_PUT, CH_RETURN, 11'd0, 1, 1, 16'h0000, 11'd0);
      add_row(CMD_PUT, CH_BACKSPACE, 11'd0, 1, 1, 16'h0000, 11'd79);
      add_row(CMD_PUT, 8'h7E, 11'd0, 1, 1, 16'h0000, 11'd80);
      add_row(CMD_PUT, CH_BACKSPACE, 11'd0, 1, 1, 16'h0000, 11'd79);
      add_row(CMD_PUT, CH_TAB, 11'd0, 1, 1, 16'h0000, 11'd83);
      add_row(CMD_PUT, CH_NEWLINE, 11'd0, 1, 1, 16'h0000, 11'd160);
      add_row(CMD_READ, 8'h00, 11'd1, 1, 1, 16'h0400, 11'd160);
      add_row(CMD_READ, 8'h00, 11'd2, 1, 1, 16'h04FF, 11'd160);
      add_row(CMD_READ, 8'h00, 11'd79, 1, 1, 16'h0420, 11'd160);
      add_row(CMD_CLEAR, 8'h00, 11'd0, 1, 1, 16'h0000, 11'd160);
      add_row(CMD_READ, 8'h00, 11'd2, 1, 1, 16'h0420, 11'd160);
      // off the bottom row, then look at what scrolled
      add_row(CMD_PUT, 8'h55, 11'd0, 1, 0, '0, '0);
      add_row(CMD_PUT, CH_NEWLINE, 11'd0, 24, 0, '0, '0);
      add_row(CMD_READ, 8'h00, 11'd1680, 1, 0, '0, '0);
      add_row(CMD_READ, 8'h00, 11'd1999, 1, 0, '0, '0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         r = directed_rows[k];
         for (i = 0; i < r.reps; i++)
            send_word(r.cmd, r.ch, r.idx, r.typed, r.data, r.pos);
      end
      drain_words();

      write_colour(8'hFF);
      run_random(150);
      drain_words();

      idle_on = 1'b0;
      write_colour(8'h00);
      run_random(100);
      drain_words();

      idle_on = 1'b1;
      write_colour(ATTR_W'($urandom_range(0, 255)));
      run_random(200);
      drain_words();

      // last stretch at full rate
      idle_on = 1'b0;
      write_colour(ATTR_W'($urandom_range(0, 255)));
      run_random(150);
      drain_words();

      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && cells_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog
   initial begin
      #60000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
